@@ hw/rtl/bira_pkg.sv @@
package bira_pkg;

  // ring of stored beat rates
  localparam int RING_DEPTH = 4;
  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RATE_W     = 8;
  localparam int SUM_W      = $clog2(255 * RING_DEPTH + 1);

  // field widths
  localparam int IR_W        = 18;
  localparam int TIME_W      = 32;
  localparam int COUNTDOWN_W = 23;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TIMEOUT   = 2'd1;

  localparam logic [IR_W-1:0]   THRESH_RESET  = IR_W'(7000);
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(30000);

  // timing constants
  localparam int MS_PER_MIN = 60000;
  localparam int MS_PER_S   = 1000;
  localparam int RATE_MIN   = 20;
  localparam int RATE_MAX   = 255;
  // 20*d < 60000 < 255*d  <=>  DELTA_MIN <= d < DELTA_LIMIT
  localparam int DELTA_MIN   = MS_PER_MIN / RATE_MAX + 1;
  localparam int DELTA_LIMIT = (MS_PER_MIN + RATE_MIN - 1) / RATE_MIN;

  // floor(x / MS_PER_S) == (x * CD_RECIP) >> CD_SHIFT for every 32-bit x
  localparam logic [TIME_W-1:0] CD_RECIP = 32'h1062_4DD3;
  localparam int                CD_SHIFT = 38;

  // serial divider
  localparam int DIV_W          = 32;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
  localparam int RATE_DIV_STEPS = 16;

  // stream widths
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_RATE,
    ST_SUM,
    ST_SLEEP_CHK,
    ST_CD_SCALE,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/beat_interval_rate_averager.sv @@
// Flow: ST_IDLE takes an item, ST_EVAL judges it; a stored rate runs the divider
//   steps (ST_DIV_RATE) and the summing pass (ST_SUM); ST_SLEEP_CHK follows, then
//   ST_CD_SCALE for the countdown scaling multiply when needed, and ST_DONE loads the output.
// Items: one in work at a time, taken only in ST_IDLE; a result held off downstream
//   stalls the block in its last state until the output register frees up.
// Reset: synchronous rst clears the ring, timing state and output valid and
//   restores the register defaults; no clearing pass.
module beat_interval_rate_averager import bira_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // ir_sample[17:0], now_ms[49:18], zero pad
  input  logic                   s_tuser,   // beat_seen
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // average_rate[7:0], sleep_countdown_s[30:8], pad
  output logic [M_TUSER_W-1:0]   m_tuser    // finger_present, rate_accepted, sleep_request
);

  state_t state, state_next;

  // configuration
  logic [IR_W-1:0]   presence_threshold;
  logic [TIME_W-1:0] sleep_timeout_ms;

  // captured item
  logic [IR_W-1:0]   ir_q;
  logic              beat_q;
  logic [TIME_W-1:0] now_q;

  // block state
  logic [RATE_W-1:0]     rate_ring [RING_DEPTH];
  logic [RING_IDX_W-1:0] ring_write_index;
  logic [TIME_W-1:0]     last_beat_time;
  logic [RATE_W-1:0]     held_average;
  logic                  absent_flag;
  logic [TIME_W-1:0]     absent_since;

  // summing pass
  logic [RING_IDX_W-1:0] sum_idx;
  logic [SUM_W-1:0]      sum_acc;
  logic [SUM_W-1:0]      sum_next;
  logic [SUM_W-1:0]      avg_full;

  // countdown scaling
  logic [TIME_W-1:0]   cd_remain;
  logic [2*TIME_W-1:0] cd_prod;

  // result fields
  logic                   res_present;
  logic                   res_accepted;
  logic                   res_sleep;
  logic [COUNTDOWN_W-1:0] res_countdown;

  // divider
  logic [DIV_W:0]     div_rem;
  logic [DIV_W-1:0]   div_dvd;
  logic [DIV_W-1:0]   div_dsr;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_W:0]     div_shift;
  logic               div_fit;
  logic [DIV_W:0]     div_rem_next;
  logic [DIV_W-1:0]   div_q_next;
  logic               div_last;

  // control strobes
  logic                 div_load;
  logic                 div_step;
  logic [DIV_W-1:0]     load_dvd;
  logic [DIV_W-1:0]     load_dsr;
  logic [DIV_CNT_W-1:0] load_steps;
  logic                 out_free;

  // item evaluation
  logic              present;
  logic              below;
  logic [TIME_W-1:0] delta;
  logic              rate_ok;
  logic [TIME_W-1:0] elapsed;
  logic              sleep_hit;
  logic              cd_needed;
  logic [TIME_W-1:0] remaining;

  assign present   = ir_q > presence_threshold;
  assign below     = ir_q < presence_threshold;
  assign delta     = now_q - last_beat_time;
  assign rate_ok   = beat_q && (delta >= TIME_W'(DELTA_MIN)) && (delta < TIME_W'(DELTA_LIMIT));
  assign elapsed   = now_q - absent_since;
  assign sleep_hit = absent_flag && (elapsed >= sleep_timeout_ms);
  assign cd_needed = absent_flag && !sleep_hit;
  assign remaining = sleep_timeout_ms - elapsed;

  assign sum_next = sum_acc + SUM_W'(rate_ring[sum_idx]);
  assign avg_full = sum_next / SUM_W'(RING_DEPTH);

  assign cd_prod = {{TIME_W{1'b0}}, cd_remain} * {{TIME_W{1'b0}}, CD_RECIP};

  // one restoring step per cycle
  assign div_shift    = {div_rem[DIV_W-1:0], div_dvd[DIV_W-1]};
  assign div_fit      = div_shift >= {1'b0, div_dsr};
  assign div_rem_next = div_fit ? (div_shift - {1'b0, div_dsr}) : div_shift;
  assign div_q_next   = {div_q[DIV_W-2:0], div_fit};
  assign div_last     = div_cnt == DIV_CNT_W'(1);

  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_EVAL;
      ST_EVAL:      state_next = (present && rate_ok) ? ST_DIV_RATE : ST_SLEEP_CHK;
      ST_DIV_RATE:  if (div_last) state_next = ST_SUM;
      ST_SUM:       if (sum_idx == RING_IDX_W'(RING_DEPTH - 1)) state_next = ST_SLEEP_CHK;
      ST_SLEEP_CHK: state_next = cd_needed ? ST_CD_SCALE : ST_DONE;
      ST_CD_SCALE:  state_next = ST_DONE;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    load_dvd   = '0;
    load_dsr   = '0;
    load_steps = '0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EVAL: begin
        if (present && rate_ok) begin
          div_load   = 1'b1;
          load_dvd   = DIV_W'(MS_PER_MIN) << (DIV_W - RATE_DIV_STEPS);
          load_dsr   = delta;
          load_steps = DIV_CNT_W'(RATE_DIV_STEPS);
        end
      end
      ST_DIV_RATE: div_step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold <= THRESH_RESET;
      sleep_timeout_ms   <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_THRESHOLD: presence_threshold <= cfg_data[IR_W-1:0];
        CFG_IDX_TIMEOUT:   sleep_timeout_ms   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= '0;
      div_dvd <= load_dvd;
      div_dsr <= load_dsr;
      div_q   <= '0;
      div_cnt <= load_steps;
    end else if (div_step) begin
      div_rem <= div_rem_next;
      div_dvd <= {div_dvd[DIV_W-2:0], 1'b0};
      div_q   <= div_q_next;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // item datapath and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        rate_ring[i] <= '0;
      end
      ring_write_index <= '0;
      last_beat_time   <= '0;
      held_average     <= '0;
      absent_flag      <= 1'b0;
      absent_since     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ir_q          <= s_tdata[IR_W-1:0];
            now_q         <= s_tdata[IR_W +: TIME_W];
            beat_q        <= s_tuser;
            res_sleep     <= 1'b0;
            res_countdown <= '0;
          end
        end
        ST_EVAL: begin
          res_present  <= present;
          res_accepted <= present && rate_ok;
          if (present) begin
            absent_flag <= 1'b0;
            if (beat_q) begin
              last_beat_time <= now_q;
            end
          end else if (below) begin
            if (!absent_flag) begin
              absent_flag  <= 1'b1;
              absent_since <= now_q;
            end
            held_average <= '0;
          end
        end
        ST_DIV_RATE: begin
          if (div_last) begin
            rate_ring[ring_write_index] <= div_q_next[RATE_W-1:0];
            if (ring_write_index == RING_IDX_W'(RING_DEPTH - 1)) begin
              ring_write_index <= '0;
            end else begin
              ring_write_index <= ring_write_index + RING_IDX_W'(1);
            end
            sum_idx <= '0;
            sum_acc <= '0;
          end
        end
        ST_SUM: begin
          sum_acc <= sum_next;
          sum_idx <= sum_idx + RING_IDX_W'(1);
          if (sum_idx == RING_IDX_W'(RING_DEPTH - 1)) begin
            held_average <= avg_full[RATE_W-1:0];
          end
        end
        ST_SLEEP_CHK: begin
          res_sleep <= sleep_hit;
          cd_remain <= remaining;
        end
        ST_CD_SCALE: res_countdown <= cd_prod[CD_SHIFT +: COUNTDOWN_W];
        default: ;
      endcase
    end
  end

  // output register, freed by the downstream transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(M_TDATA_W - RATE_W - COUNTDOWN_W){1'b0}}, res_countdown, held_average};
      m_tuser <= {res_sleep, res_accepted, res_present};
    end
  end

endmodule

@@ hw/rtl/bira_checker.sv @@
module bira_checker import bira_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [S_TDATA_W-1:0]   s_tdata,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_TDATA_W-1:0]   m_tdata,
  input logic [M_TUSER_W-1:0]   m_tuser
);

  // one item in flight: input side closes right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous item still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // a sleep request never comes with a running countdown
  a_sleep_countdown: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tdata[30:8] == '0))
    else $error("countdown nonzero with sleep request");

  a_accept_needs_finger: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && !m_tuser[2]))
    else $error("rate stored without finger present");

  a_average_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'hFF))
    else $error("average rate out of range");

endmodule

bind beat_interval_rate_averager bira_checker u_bira_checker (.*);

@@ tb/beat_interval_rate_averager_test.sv @@
module beat_interval_rate_averager_test;
  import bira_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 70;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int LONG_HOLD      = 300;
  localparam logic [IR_W-1:0] IR_MAX = '1;

  // register indexes the block does not decode
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  // result field positions
  localparam int USER_FINGER   = 0;
  localparam int USER_ACCEPTED = 1;
  localparam int USER_SLEEP    = 2;
  localparam int DATA_AVG_LSB  = 0;
  localparam int DATA_CD_LSB   = RATE_W;

  typedef struct packed {
    logic                   finger;
    logic [RATE_W-1:0]      avg;
    logic                   accepted;
    logic                   sleep;
    logic [COUNTDOWN_W-1:0] countdown;
  } reading_t;

  class rate_scoreboard;
    logic [IR_W-1:0]   threshold;
    logic [TIME_W-1:0] timeout;
    logic [RATE_W-1:0] ring [RING_DEPTH];
    int unsigned       wr_idx;
    logic [TIME_W-1:0] last_beat;
    logic [RATE_W-1:0] avg;
    logic              absent;
    logic [TIME_W-1:0] absent_since;
    reading_t          pending_readings[$];
    int                errors;
    int                rates_stored;
    int                sleeps_seen;
    int                readings_checked;

    function new();
      threshold = THRESH_RESET;
      timeout   = TIMEOUT_RESET;
      foreach (ring[i]) ring[i] = '0;
      wr_idx       = 0;
      last_beat    = '0;
      avg          = '0;
      absent       = 1'b0;
      absent_since = '0;
      errors       = 0;
      rates_stored = 0;
      sleeps_seen  = 0;
      readings_checked = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IDX_THRESHOLD: threshold = val[IR_W-1:0];
        CFG_IDX_TIMEOUT:   timeout = val[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [IR_W-1:0] ir, logic beat, logic [TIME_W-1:0] now);
      reading_t          r;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] remain;
      logic [63:0]       d;
      int unsigned       sum;
      r = '0;
      r.finger = ir > threshold;
      if (r.finger) begin
        absent = 1'b0;
        if (beat) begin
          delta = now - last_beat;
          last_beat = now;
          d = 64'(delta);
          if (d * 64'(RATE_MIN) < 64'(MS_PER_MIN) && 64'(MS_PER_MIN) < d * 64'(RATE_MAX)) begin
            ring[wr_idx] = RATE_W'(32'(MS_PER_MIN) / delta);
            wr_idx = (wr_idx + 1) % RING_DEPTH;
            sum = 0;
            foreach (ring[i]) sum += ring[i];
            avg = RATE_W'(sum / RING_DEPTH);
            r.accepted = 1'b1;
            rates_stored++;
          end
        end
      end else if (ir < threshold) begin
        if (!absent) begin
          absent = 1'b1;
          absent_since = now;
        end
        avg = '0;
      end
      if (absent) begin
        elapsed = now - absent_since;
        if (elapsed >= timeout) begin
          r.sleep = 1'b1;
          sleeps_seen++;
        end else begin
          remain = (timeout - elapsed) / 32'(MS_PER_S);
          r.countdown = remain[COUNTDOWN_W-1:0];
        end
      end
      r.avg = avg;
      pending_readings.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_reading(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      reading_t exp;
      if (pending_readings.size() == 0) begin
        $error("result with nothing pending: tdata=%h tuser=%b", data, user);
        errors++;
        return;
      end
      exp = pending_readings.pop_front();
      readings_checked++;
      compare_field("finger_present", exp.finger, user[USER_FINGER]);
      compare_field("average_rate", exp.avg, data[DATA_AVG_LSB +: RATE_W]);
      compare_field("rate_accepted", exp.accepted, user[USER_ACCEPTED]);
      compare_field("sleep_request", exp.sleep, user[USER_SLEEP]);
      compare_field("sleep_countdown_s", exp.countdown, data[DATA_CD_LSB +: COUNTDOWN_W]);
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;   // ir_sample, now_ms, zero pad
  logic                   s_tuser = 1'b0; // beat_seen
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;        // average_rate, sleep_countdown_s, pad
  logic [M_TUSER_W-1:0]   m_tuser;        // finger_present, rate_accepted, sleep_request

  rate_scoreboard    sb;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                rx_hold_cycles = 0;
  int                items_sent = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [TIME_W-1:0] beat_ref_ms = '0;

  beat_interval_rate_averager dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // result side: check, then pick next tready (long hold takes priority)
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_reading(m_tdata, m_tuser);
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("** beat_interval_rate_averager: FAILED **");
    $finish;
  end

  task automatic send_item(input logic [IR_W-1:0] ir, input logic beat,
                           input logic [TIME_W-1:0] now);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-IR_W-TIME_W){1'b0}}, now, ir};
    s_tuser  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(ir, beat, now);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // drop tvalid, let every reading come back, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IR_W-1:0] present_ir();
    if (sb.threshold == IR_MAX) return IR_MAX;
    return IR_W'($urandom_range(IR_MAX, 32'(sb.threshold) + 1));
  endfunction

  function automatic logic [IR_W-1:0] absent_ir();
    if (sb.threshold == '0) return '0;
    return IR_W'($urandom_range(32'(sb.threshold) - 1, 0));
  endfunction

  task automatic send_random_item();
    int                pick;
    int                n;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] ahead;
    logic [TIME_W-1:0] step;
    logic [IR_W-1:0]   ir;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // well-formed run: some plain samples, then a beat at a planned interval
      case ($urandom_range(11))
        0: gap = 235;
        1: gap = 236;
        2: gap = 2999;
        3: gap = 3000;
        4: gap = $urandom_range(100, 0);
        5: gap = $urandom_range(20000, 3000);
        default: gap = $urandom_range(2999, 236);
      endcase
      n = $urandom_range(3, 0);
      target = beat_ref_ms + gap;
      ahead = target - clock_ms;
      if (ahead[TIME_W-1]) begin
        target = clock_ms + gap;
        ahead = gap;
      end
      step = ahead / (n + 1);
      repeat (n) begin
        clock_ms += step;
        send_item(present_ir(), 1'b0, clock_ms);
      end
      clock_ms = target;
      beat_ref_ms = target;
      send_item(present_ir(), 1'b1, clock_ms);
    end else if (pick < 75) begin
      // absence stretch, long enough to reach the timeout now and then
      n = $urandom_range(6, 1);
      repeat (n) begin
        if (sb.timeout < 200000)
          clock_ms += $urandom_range(sb.timeout / 3 + 1000, 0);
        else if ($urandom_range(9) == 0)
          clock_ms += $urandom;
        else
          clock_ms += $urandom_range(3000, 0);
        send_item(absent_ir(), 1'(($urandom)), clock_ms);
      end
    end else if (pick < 82) begin
      clock_ms += $urandom_range(500, 0);
      send_item(sb.threshold, 1'(($urandom)), clock_ms);
    end else begin
      ir = IR_W'($urandom);
      if ($urandom_range(99) < 30) clock_ms = $urandom;
      else clock_ms += $urandom_range(5000, 0);
      send_item(ir, 1'(($urandom)), clock_ms);
    end
  endtask

  task automatic configure_phase(input int p);
    logic [CFG_DATA_W-1:0] thr_word;
    logic [CFG_DATA_W-1:0] tmo;
    // upper bits above the 18-bit threshold are junk the block must drop
    thr_word = ($urandom & ~32'(IR_MAX)) | 32'($urandom_range(IR_MAX - 1, 1));
    tmo = ($urandom_range(3) == 0) ? $urandom : $urandom_range(60000, 1);
    case (p)
      0: begin
        thr_word = 32'(THRESH_RESET);
        tmo = 32'(TIMEOUT_RESET);
      end
      1: begin
        thr_word = '0;
        tmo = $urandom_range(20000, 0);
      end
      2: begin
        thr_word = 32'(IR_MAX);
        tmo = 5000;
      end
      3: tmo = '0;
      4: tmo = '1;
      5: begin
        write_reg(CFG_IDX_SPARE_A, $urandom);
        write_reg(CFG_IDX_SPARE_B, $urandom);
      end
      default: ;
    endcase
    write_reg(CFG_IDX_THRESHOLD, thr_word);
    write_reg(CFG_IDX_TIMEOUT, tmo);
  endtask

  initial begin
    int  goal;
    bit  hold_done;
    bit  pause_done;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset register values
    send_item('0, 1'b0, 32'd0);
    send_item(IR_MAX, 1'b1, 32'd1000);
    send_item(THRESH_RESET, 1'b1, 32'd1100);          // at threshold: nothing moves
    send_item(THRESH_RESET + 1, 1'b1, 32'd1236);      // shortest interval kept
    send_item(IR_W'(200000), 1'b1, 32'd1471);         // one ms too short
    send_item(IR_W'(200000), 1'b1, 32'd4470);         // longest interval kept
    send_item(IR_W'(200000), 1'b1, 32'd7470);         // one ms too long
    send_item(IR_W'(200000), 1'b1, 32'd7470);         // zero interval
    send_item(IR_W'(200000), 1'b0, 32'd8000);
    send_item(IR_W'(200000), 1'b1, 32'hFFFF_FF00);
    send_item(IR_W'(200000), 1'b1, 32'h0000_0200);    // interval across the wrap
    send_item(IR_W'(200000), 1'b1, 32'h0000_03F4);    // ring wraps around
    send_item(THRESH_RESET - 1, 1'b1, 32'd100000);    // beat while absent is ignored
    send_item('0, 1'b0, 32'd129999);
    send_item('0, 1'b0, 32'd130000);                  // timeout reached
    send_item(THRESH_RESET, 1'b0, 32'd200000);        // request held at threshold
    send_item(THRESH_RESET + 1, 1'b0, 32'd200001);    // finger back: request drops
    send_item('0, 1'b0, 32'hFFFF_FFF0);
    send_item('0, 1'b1, 32'h0000_0010);               // absence timed across the wrap
    send_item('0, 1'b0, 32'hFFFF_FFFF);
    send_item(IR_MAX, 1'b1, 32'hFFFF_FFFF);
    send_item(IR_MAX, 1'b1, 32'h0000_0200);
    wait_idle();

    hold_done = 1'b0;
    pause_done = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      configure_phase(p);
      if (p % 2 == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(200000, 0);
      else clock_ms = $urandom;
      beat_ref_ms = clock_ms;
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if (p == 4 && !hold_done && items_sent + 60 >= goal) begin
          // receiver stops for a long stretch while the sender keeps pushing
          rx_hold_cycles = LONG_HOLD;
          hold_done = 1'b1;
        end
        if (p == 6 && !pause_done && items_sent + 40 >= goal) begin
          wait_idle();
          pause_done = 1'b1;
        end
        send_random_item();
      end
      wait_idle();
    end

    if (sb.pending() != 0) begin
      $error("%0d readings never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d samples over %0d register settings; %0d readings checked,",
             items_sent, PHASES + 1, sb.readings_checked);
    $display("  %0d beat rates stored and %0d sleep requests expected.",
             sb.rates_stored, sb.sleeps_seen);
    if (sb.errors == 0) begin
      $display("** beat_interval_rate_averager: PASSED **");
    end else begin
      $display("** beat_interval_rate_averager: FAILED **");
    end
    $finish;
  end

endmodule

@@ beat_interval_rate_averager.f @@
hw/rtl/bira_pkg.sv
hw/rtl/beat_interval_rate_averager.sv
hw/rtl/bira_checker.sv
tb/beat_interval_rate_averager_test.sv
